// File: design/psqrl_pkg.sv
// Shared types and constants for the per-source query rate limiter.
`timescale 1ns / 1ps
`default_nettype none
package psqrl_pkg;

  localparam int          ADDR_W        = 32;
  localparam int          TIME_W        = 32;
  localparam int          WIN_W         = 16;
  localparam int          CFG_ADDR_W    = 3;
  localparam logic [WIN_W-1:0]      WINDOW_RESET = WIN_W'(5 * 1000);
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW   = 3'd0;

  // One table entry as it moves between neighboring cells
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] tstamp;
    logic              valid;
  } entry_t;

  // Phase strobes broadcast to every cell
  typedef struct packed {
    logic cmp_en;
    logic upd_en;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// File: design/psqrl_cell.sv
// One slot of the source table: ages out, matches and shifts toward older slots.
`timescale 1ns / 1ps
`default_nettype none
module psqrl_cell (
  input  wire                               clk,
  input  wire                               rst_n,
  input  psqrl_pkg::cell_ctrl_t             ctrl,
  input  wire  [psqrl_pkg::ADDR_W-1:0]      q_addr,
  input  wire  [psqrl_pkg::TIME_W-1:0]      q_now,
  input  wire  [psqrl_pkg::WIN_W-1:0]       window,
  input  wire                               hit,
  input  psqrl_pkg::entry_t                 entry_in,
  input  wire                               chain_in,
  output psqrl_pkg::entry_t                 entry_out,
  output logic                              chain_out,
  output logic                              match
);
  import psqrl_pkg::*;

  logic [ADDR_W-1:0] addr_r;
  logic [TIME_W-1:0] tstamp_r;
  logic              valid_r;
  logic              match_r;
  logic [TIME_W-1:0] age;
  logic              live;

  // wrap-safe age against the zero-extended window
  assign age  = q_now - tstamp_r;
  assign live = valid_r && (age < {{(TIME_W-WIN_W){1'b0}}, window});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else if (ctrl.cmp_en) begin
      valid_r <= live;
      match_r <= live && (addr_r == q_addr);
    end else if (ctrl.upd_en && !hit && chain_in) begin
      valid_r <= entry_in.valid;
    end
  end

  // every younger slot is occupied, so this one takes its neighbor's entry
  always_ff @(posedge clk) begin
    if (ctrl.upd_en && !hit && chain_in) begin
      addr_r   <= entry_in.addr;
      tstamp_r <= entry_in.tstamp;
    end
  end

  assign entry_out.addr   = addr_r;
  assign entry_out.tstamp = tstamp_r;
  assign entry_out.valid  = valid_r;
  assign chain_out        = chain_in && valid_r;
  assign match            = match_r;

endmodule
`default_nettype wire

// File: design/per_source_query_rate_limiter.sv
// Per-source query rate limiter: table of recent sources held in a chain of cells.
// Each accepted word passes the age/compare phase, then the update phase, to give its result word.
// A new query is accepted only when idle, after the compare and update phases of the cell row;
//   the update phase waits while the previous result word is still held.
// Reset (rst_n, synchronous): all slots invalid, window_ms = 5000, no result pending.
`timescale 1ns / 1ps
`default_nettype none
module per_source_query_rate_limiter #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [63:0] in_tdata,     // [31:0] source_address, [63:32] now_ms
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,    // [0] allowed, [7:1] zero
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [psqrl_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import psqrl_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_UPD} state_t;

  state_t            state_r;
  logic [WIN_W-1:0]  window_r;
  logic [ADDR_W-1:0] q_addr_r;
  logic [TIME_W-1:0] q_now_r;
  logic              out_valid_r;
  logic              allowed_r;
  logic              upd_go;
  logic              hit;
  cell_ctrl_t        ctrl;

  entry_t            entry_chain [TABLE_DEPTH+1];
  logic [TABLE_DEPTH:0]   chain;
  logic [TABLE_DEPTH-1:0] match_vec;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_WINDOW) ? {{(32-WIN_W){1'b0}}, window_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == REG_WINDOW) begin
      window_r <= cfg_pwdata[WIN_W-1:0];
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign upd_go     = (state_r == S_UPD) && (!out_valid_r || out_tready);
  assign ctrl.cmp_en = (state_r == S_CMP);
  assign ctrl.upd_en = upd_go;
  assign hit        = |match_vec;

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      q_addr_r <= in_tdata[31:0];
      q_now_r  <= in_tdata[63:32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      allowed_r   <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          state_r <= S_UPD;
        end
        S_UPD: begin
          if (upd_go) begin
            allowed_r   <= !hit;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, allowed_r};

  // the new query enters the youngest slot
  assign entry_chain[0].addr   = q_addr_r;
  assign entry_chain[0].tstamp = q_now_r;
  assign entry_chain[0].valid  = 1'b1;
  assign chain[0]              = 1'b1;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    psqrl_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .q_addr    (q_addr_r),
      .q_now     (q_now_r),
      .window    (window_r),
      .hit       (hit),
      .entry_in  (entry_chain[i]),
      .chain_in  (chain[i]),
      .entry_out (entry_chain[i+1]),
      .chain_out (chain[i+1]),
      .match     (match_vec[i])
    );
  end

endmodule
`default_nettype wire

// File: dv/psqrl_checker.sv
// Checker for the query rate limiter: tracks the source table and compares every verdict word.
`timescale 1ns / 1ps
module psqrl_checker #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  input  wire                  in_tready,
  input  wire  [63:0]          in_tdata,     // [31:0] source_address, [63:32] now_ms
  input  wire                  out_tvalid,
  input  wire                  out_tready,
  input  wire  [7:0]           out_tdata,    // [0] allowed, [7:1] zero
  input  wire                  cfg_psel,
  input  wire                  cfg_penable,
  input  wire                  cfg_pwrite,
  input  wire  [psqrl_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire  [31:0]          cfg_pwdata,
  input  wire  [31:0]          cfg_prdata,
  input  wire                  cfg_pready,
  output int                   verdicts_owed,
  output int                   error_count
);
  import psqrl_pkg::*;

  logic [WIN_W-1:0]  window_ms_q;
  logic [ADDR_W-1:0] src_addr [TABLE_DEPTH];
  logic [TIME_W-1:0] src_time [TABLE_DEPTH];
  logic              src_live [TABLE_DEPTH];
  logic              verdict_q [$];
  logic              want;

  initial error_count = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    error_count++;
  endtask

  // Age out stale sources, look for a live match, record the source when there is none.
  function automatic logic judge_query(input logic [ADDR_W-1:0] addr,
                                       input logic [TIME_W-1:0] now);
    logic              hit;
    logic [TIME_W-1:0] age;
    int                hole;
    int                i;
    hit = 1'b0;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      if (src_live[i]) begin
        age = now - src_time[i];
        if (age >= TIME_W'(window_ms_q))
          src_live[i] = 1'b0;
        else if (src_addr[i] == addr)
          hit = 1'b1;
      end
    end
    if (!hit) begin
      hole = TABLE_DEPTH - 1;
      for (i = TABLE_DEPTH - 1; i >= 0; i--)
        if (!src_live[i])
          hole = i;
      for (i = hole; i > 0; i--) begin
        src_addr[i] = src_addr[i-1];
        src_time[i] = src_time[i-1];
        src_live[i] = src_live[i-1];
      end
      src_addr[0] = addr;
      src_time[0] = now;
      src_live[0] = 1'b1;
    end
    return !hit;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      window_ms_q = WINDOW_RESET;
      for (int i = 0; i < TABLE_DEPTH; i++)
        src_live[i] = 1'b0;
      verdict_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          if (cfg_paddr == REG_WINDOW)
            window_ms_q = cfg_pwdata[WIN_W-1:0];
        end else if (cfg_paddr == REG_WINDOW && cfg_prdata !== 32'(window_ms_q)) begin
          report_mismatch($sformatf("window_ms read %h, expected %h", cfg_prdata,
                                    window_ms_q));
        end
      end
      // results leave only after their query has been accepted, so pop before push
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("verdict word %h with no query outstanding", out_tdata));
        end else begin
          want = verdict_q.pop_front();
          if (out_tdata[0] !== want)
            report_mismatch($sformatf("allowed %b, expected %b", out_tdata[0], want));
          if (out_tdata[7:1] !== 7'd0)
            report_mismatch($sformatf("pad bits %h not zero", out_tdata[7:1]));
        end
      end
      if (in_tvalid && in_tready)
        verdict_q.push_back(judge_query(in_tdata[31:0], in_tdata[63:32]));
    end
    verdicts_owed <= verdict_q.size();
  end

endmodule

// File: dv/tb.sv
// Testbench top for the query rate limiter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
  import psqrl_pkg::*;

  localparam int TABLE_DEPTH  = 16;
  localparam int CYCLE_LIMIT  = 400_000;
  localparam int MAX_WAIT     = 18;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASES       = 8;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 3'd4;   // no register decodes here

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [63:0]           in_tdata;     // [31:0] source_address, [63:32] now_ms
  logic                  out_tvalid;
  logic                  out_tready;
  logic [7:0]            out_tdata;    // [0] allowed, [7:1] zero
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;
  int                    verdicts_owed;
  int                    error_count;
  int                    cycles;
  bit                    tx_eager;
  bit                    rx_eager;

  per_source_query_rate_limiter #(.TABLE_DEPTH(TABLE_DEPTH)) dut (.*);

  psqrl_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // result side: random stalls, with stretches of none
  initial begin
    int stall;
    int taken;
    taken = 0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken % 64 == 0)
        rx_eager = ($urandom_range(0, 2) == 0);
      stall = rx_eager ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      taken++;
    end
  end

  task automatic send_query(input logic [ADDR_W-1:0] addr, input logic [TIME_W-1:0] now);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {now, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (verdicts_owed != 0) @(posedge clk);
  endtask

  task automatic cfg_access(input bit wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_directed();
    int i;
    send_query(32'h0000_0000, 32'd0);
    send_query(32'h0000_0000, 32'd4999);       // one tick short of the window: refused
    send_query(32'h0000_0000, 32'd5000);       // exactly the window: expired, allowed
    send_query(32'hFFFF_FFFF, 32'd5001);
    send_query(32'hFFFF_FFFF, 32'd5002);
    send_query(32'hFFFF_FFFF, 32'd5000);       // time stepped back: entry looks ancient
    // seventeen sources across the tick wrap overflow the table
    for (i = 0; i <= TABLE_DEPTH; i++)
      send_query(32'hA5A5_0000 + i, 32'hFFFF_FFF8 + i);
    send_query(32'hA5A5_0000, 32'h0000_0009);  // dropped as oldest, so allowed again
    send_query(32'hA5A5_0002, 32'h0000_000A);  // still held: refused
  endtask

  // Mostly a small pool of sources revisiting within the window; some boundary pairs,
  // stray sources, backward steps and jumps of the tick.
  task automatic run_traffic(input int count, input logic [WIN_W-1:0] win);
    logic [ADDR_W-1:0] pool [40];
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] now;
    int                n;
    int                sent;
    int                sel;
    int                span;
    int                hold_at;
    n = $urandom_range(2, 40);
    for (int i = 0; i < 40; i++)
      pool[i] = $urandom();
    now     = $urandom();
    span    = int'(win) / 4 + 1;
    hold_at = $urandom_range(20, count - 20);
    sent    = 0;
    while (sent < count) begin
      if (sent % 64 == 0)
        tx_eager = ($urandom_range(0, 2) == 0);
      if (sent == hold_at)
        drain();
      sel  = $urandom_range(0, 99);
      addr = pool[$urandom_range(0, n - 1)];
      if (sel < 70) begin
        now += $urandom_range(0, span);
      end else if (sel < 80) begin
        send_query(addr, now);
        sent++;
        now += TIME_W'(win) - $urandom_range(0, 1);
      end else if (sel < 88) begin
        addr = $urandom();
        now += $urandom_range(0, span);
      end else if (sel < 94) begin
        now -= $urandom_range(1, span);
      end else begin
        now = $urandom();
      end
      send_query(addr, now);
      sent++;
    end
  endtask

  initial begin
    logic [WIN_W-1:0] plan [PHASES];
    int               p;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    rst_n       <= 1'b0;
    tx_eager     = 1'b0;
    plan = '{WINDOW_RESET, 16'd1, 16'hFFFF, 16'd0, 16'($urandom_range(1, 65535)),
             16'd40, 16'($urandom_range(1, 2000)), WINDOW_RESET};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_access(1'b0, REG_WINDOW, '0);
    run_directed();
    for (p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (p == 4)
          cfg_access(1'b1, REG_SPARE, $urandom());
        cfg_access(1'b1, REG_WINDOW, {16'($urandom()), plan[p]});
        cfg_access(1'b0, REG_WINDOW, '0);
      end
      run_traffic($urandom_range(200, 270), plan[p]);
    end
    drain();
    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && verdicts_owed == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// File: files.f
design/psqrl_pkg.sv
design/psqrl_cell.sv
design/per_source_query_rate_limiter.sv
dv/psqrl_checker.sv
dv/tb.sv
